// ----- sv/dbp_pkg.sv -----
package dbp_pkg;

  localparam int MAX_CLASSES  = 256;
  localparam int CLASS_W      = 8;
  localparam int SIG_DEPTH    = 1024;
  localparam int SIG_IDX_W    = $clog2(SIG_DEPTH);
  localparam int SIG_HALF     = 4096;
  localparam int SIG_OFF_W    = 13;
  localparam int QUEUE_DEPTH  = 4;
  localparam int Q_PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int IMG_MAX      = 8192;
  localparam int VAL_W        = 26;
  localparam int PROD_W       = 51;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam logic CMD_LOGIT = 1'b0;
  localparam logic CMD_BOX   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_W   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_H   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_W   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_H   = 3'd5;

  localparam logic [16:0] RST_THRESHOLD = 17'd32768;
  localparam logic [12:0] RST_MODEL_DIM = 13'd640;

  localparam logic [63:0] LOG2E_Q16 = 64'd94548;
  localparam logic [63:0] POW2_NEG_FRAC [8] = '{
    64'd65359, 64'd65182, 64'd64830, 64'd64132,
    64'd62757, 64'd60097, 64'd55109, 64'd46341
  };

  typedef struct packed {
    logic [16:0] threshold;
    logic [12:0] model_w;
    logic [12:0] model_h;
    logic [23:0] inv_scale;
    logic [13:0] image_w;
    logic [13:0] image_h;
  } cfg_t;

  typedef struct packed {
    logic                 have_score;
    logic signed [15:0]   best_logit;
    logic [CLASS_W-1:0]   best_class;
    logic signed [15:0]   cx;
    logic signed [15:0]   cy;
    logic signed [15:0]   bw;
    logic signed [15:0]   bh;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef logic [15:0] sig_table_t [SIG_DEPTH];

  // 2^-(|x|*log2e) in q16, then round(2^32/(65536+p)) by long division
  function automatic logic [15:0] sig_at(input int xq);
    logic [63:0] a;
    logic [63:0] u;
    logic [63:0] ip;
    logic [63:0] fp;
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] s;
    int          k;
    int          i;
    a = (xq < 0) ? 64'(-xq) : 64'(xq);
    u = (a * LOG2E_Q16 + 64'd128) >> 8;
    ip = u >> 16;
    fp = (u >> 8) & 64'hFF;
    p = 64'd65536;
    for (k = 0; k < 8; k++) begin
      if (fp[k]) begin
        p = (p * POW2_NEG_FRAC[k] + 64'd32768) >> 16;
      end
    end
    if (ip >= 64'd17) begin
      p = 64'd0;
    end else begin
      p = p >> ip;
    end
    d = 64'd65536 + p;
    num = (64'd1 << 32) + (d >> 1);
    q = 64'd0;
    rem = 64'd0;
    for (i = 33; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 64'd1);
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 64'd1;
      end
    end
    s = (xq >= 0) ? q : (64'd65536 - q);
    return (s > 64'd65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic sig_table_t gen_sig_table();
    sig_table_t t;
    int         c;
    int         i;
    for (i = 0; i < SIG_DEPTH; i++) begin
      c = ((2 * i + 1) * (2 * SIG_HALF)) / (2 * SIG_DEPTH) - SIG_HALF;
      t[i] = sig_at(c);
    end
    return t;
  endfunction

endpackage

// ----- sv/dbp_in_if.sv -----
interface dbp_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] class_logit;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic signed [15:0] box_w;
  logic signed [15:0] box_h;

  modport source (
    output valid, command, class_logit, center_x, center_y, box_w, box_h,
    input  ready
  );
  modport sink (
    input  valid, command, class_logit, center_x, center_y, box_w, box_h,
    output ready
  );
endinterface

// ----- sv/dbp_out_if.sv -----
interface dbp_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] rect_x;
  logic [12:0] rect_y;
  logic [13:0] rect_width;
  logic [13:0] rect_height;
  logic [7:0]  class_id;
  logic [15:0] confidence_out;

  modport source (
    output valid, rect_x, rect_y, rect_width, rect_height, class_id, confidence_out,
    input  ready
  );
  modport sink (
    input  valid, rect_x, rect_y, rect_width, rect_height, class_id, confidence_out,
    output ready
  );
endinterface

// ----- sv/dbp_cfg_if.sv -----
interface dbp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dbp_pkg::CFG_IDX_W-1:0]   index;
  logic [dbp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/detection_box_postprocess.sv -----
// channel  | dir | transaction payload
// in_chan  | in  | command, class_logit, center_x, center_y, box_w, box_h
// out_chan | out | rect_x, rect_y, rect_width, rect_height, class_id, confidence_out
// cfg_chan | in  | index, data (register write, always ready)
//
// front takes one item per cycle while the 4-entry box queue has room
// back drops a box without a score or below threshold; emitting one adds rescaling if set
// (one shared 26x25 multiplier, a multiply and a rounding state per value)
// a stalled output holds the result register; back then waits, queue fills
// synchronous active-low reset clears detection state and queue, and restores config defaults

module detection_box_postprocess (
  input  logic    clk,
  input  logic    rst_n,
  dbp_in_if.sink  in_chan,
  dbp_out_if.source out_chan,
  dbp_cfg_if.sink cfg_chan
);

  dbp_pkg::cfg_t    cfg_r;
  dbp_pkg::push_t   q_push;
  dbp_pkg::entry_t  q_head;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= dbp_pkg::RST_THRESHOLD;
      cfg_r.model_w   <= dbp_pkg::RST_MODEL_DIM;
      cfg_r.model_h   <= dbp_pkg::RST_MODEL_DIM;
      cfg_r.inv_scale <= '0;
      cfg_r.image_w   <= '0;
      cfg_r.image_h   <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        dbp_pkg::REG_THRESHOLD: cfg_r.threshold <= cfg_chan.data[16:0];
        dbp_pkg::REG_MODEL_W:   cfg_r.model_w   <= cfg_chan.data[12:0];
        dbp_pkg::REG_MODEL_H:   cfg_r.model_h   <= cfg_chan.data[12:0];
        dbp_pkg::REG_INV_SCALE: cfg_r.inv_scale <= cfg_chan.data[23:0];
        dbp_pkg::REG_IMAGE_W:   cfg_r.image_w   <= cfg_chan.data[13:0];
        dbp_pkg::REG_IMAGE_H:   cfg_r.image_h   <= cfg_chan.data[13:0];
        default: ;
      endcase
    end
  end

  dbp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push)
  );

  dbp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  dbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ----- sv/dbp_front.sv -----
module dbp_front (
  input  logic            clk,
  input  logic            rst_n,
  dbp_in_if.sink          in_chan,
  input  logic            q_full,
  output dbp_pkg::push_t  q_push
);

  logic                            have_r;
  logic signed [15:0]              best_r;
  logic [dbp_pkg::CLASS_W-1:0]     class_r;
  logic [dbp_pkg::CLASS_W-1:0]     cnt_r;
  logic [dbp_pkg::CLASS_W:0]       next_idx;
  logic                            accept;
  logic                            take_logit;

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && in_chan.ready;

  assign next_idx = have_r ? ({1'b0, cnt_r} + (dbp_pkg::CLASS_W+1)'(1))
                           : '0;
  // logits past the class limit are dropped
  assign take_logit = accept && (in_chan.command == dbp_pkg::CMD_LOGIT) &&
                      (next_idx < (dbp_pkg::CLASS_W+1)'(dbp_pkg::MAX_CLASSES));

  always_comb begin
    q_push.push             = accept && (in_chan.command == dbp_pkg::CMD_BOX);
    q_push.entry.have_score = have_r;
    q_push.entry.best_logit = best_r;
    q_push.entry.best_class = class_r;
    q_push.entry.cx         = in_chan.center_x;
    q_push.entry.cy         = in_chan.center_y;
    q_push.entry.bw         = in_chan.box_w;
    q_push.entry.bh         = in_chan.box_h;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r  <= 1'b0;
      best_r  <= '0;
      class_r <= '0;
      cnt_r   <= '0;
    end else if (q_push.push) begin
      have_r  <= 1'b0;
      best_r  <= '0;
      class_r <= '0;
      cnt_r   <= '0;
    end else if (take_logit) begin
      if (!have_r || (in_chan.class_logit > best_r)) begin
        best_r  <= in_chan.class_logit;
        class_r <= next_idx[dbp_pkg::CLASS_W-1:0];
      end
      cnt_r  <= next_idx[dbp_pkg::CLASS_W-1:0];
      have_r <= 1'b1;
    end
  end

endmodule

// ----- sv/dbp_queue.sv -----
module dbp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  dbp_pkg::push_t   q_push,
  output logic             q_full,
  output logic             q_valid,
  output dbp_pkg::entry_t  q_head,
  input  logic             q_pop
);

  dbp_pkg::entry_t               mem_r [dbp_pkg::QUEUE_DEPTH];
  logic [dbp_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [dbp_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [dbp_pkg::Q_CNT_W-1:0]   count_r;
  logic [dbp_pkg::Q_CNT_W-1:0]   count_nxt;

  localparam logic [dbp_pkg::Q_PTR_W-1:0] PTR_LAST =
    dbp_pkg::Q_PTR_W'(dbp_pkg::QUEUE_DEPTH - 1);
  localparam logic [dbp_pkg::Q_CNT_W-1:0] CNT_FULL =
    dbp_pkg::Q_CNT_W'(dbp_pkg::QUEUE_DEPTH);

  assign q_full  = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (q_push.push && !q_pop) begin
      count_nxt = count_r + dbp_pkg::Q_CNT_W'(1);
    end else if (!q_push.push && q_pop) begin
      count_nxt = count_r - dbp_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (q_push.push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + dbp_pkg::Q_PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + dbp_pkg::Q_PTR_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push.push)
    else $error("push into full queue");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_push.push) |=> (count_r == $past(count_r) - dbp_pkg::Q_CNT_W'(1)))
    else $error("pop did not lower the count");

endmodule

// ----- sv/dbp_back.sv -----
module dbp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  dbp_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  dbp_pkg::entry_t  q_head,
  output logic             q_pop,
  dbp_out_if.source        out_chan
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_RND   = 7'b0001000,
    S_CLXY  = 7'b0010000,
    S_CLWH  = 7'b0100000,
    S_OUT   = 7'b1000000
  } back_state_t;

  localparam int VW = dbp_pkg::VAL_W;
  localparam int PW = dbp_pkg::PROD_W;
  localparam int CW = dbp_pkg::VAL_W + 1;
  localparam int IW = dbp_pkg::SIG_OFF_W + dbp_pkg::SIG_IDX_W + 1;
  localparam logic [2:0] STEP_LAST_PLAIN  = 3'd3;
  localparam logic [2:0] STEP_LAST_SCALED = 3'd7;
  localparam logic [13:0] IMG_MAX_W = 14'(dbp_pkg::IMG_MAX);
  localparam logic signed [CW-1:0] ONE_S = CW'(1);
  localparam logic signed [15:0] SIG_LO = 16'(-dbp_pkg::SIG_HALF);
  localparam logic signed [15:0] SIG_HI = 16'(dbp_pkg::SIG_HALF - 1);

  localparam dbp_pkg::sig_table_t SIG_TABLE = dbp_pkg::gen_sig_table();

  back_state_t               state_r;
  back_state_t               state_nxt;
  dbp_pkg::entry_t           ent_r;
  logic [15:0]               conf_r;
  logic [2:0]                step_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [VW-1:0]      val_r [4];
  logic                      out_valid_r;
  logic [12:0]               rx_r;
  logic [12:0]               ry_r;
  logic [13:0]               rw_r;
  logic [13:0]               rh_r;
  logic [7:0]                cls_r;
  logic [15:0]               cf_r;

  logic signed [15:0]        lg_c;
  logic [dbp_pkg::SIG_OFF_W-1:0] lg_off;
  logic [IW-1:0]             idx_prod;
  logic [dbp_pkg::SIG_IDX_W-1:0] sig_idx;
  logic                      keep;
  logic [2:0]                step_last;
  logic signed [VW-1:0]      mul_a;
  logic [23:0]               mul_b;
  logic signed [24:0]        mul_b_s;
  logic signed [PW-1:0]      prod_nxt;
  logic [PW-1:0]             mag;
  logic [PW-1:0]             rnd;
  logic [PW-1:0]             res;
  logic [13:0]               ow;
  logic [13:0]               oh;
  logic signed [CW-1:0]      ow_s;
  logic signed [CW-1:0]      oh_s;
  logic signed [CW-1:0]      x_c;
  logic signed [CW-1:0]      y_c;
  logic signed [CW-1:0]      w_c;
  logic signed [CW-1:0]      h_c;
  logic                      out_load;

  // sigmoid table address from the winning logit
  always_comb begin
    lg_c = q_head.best_logit;
    if (lg_c < SIG_LO) lg_c = SIG_LO;
    if (lg_c > SIG_HI) lg_c = SIG_HI;
    lg_off   = dbp_pkg::SIG_OFF_W'(lg_c - SIG_LO);
    idx_prod = IW'(lg_off) * IW'(dbp_pkg::SIG_DEPTH);
    sig_idx  = idx_prod[dbp_pkg::SIG_OFF_W +: dbp_pkg::SIG_IDX_W];
  end

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign keep  = ent_r.have_score && ({1'b0, conf_r} >= cfg.threshold);
  assign step_last = (cfg.inv_scale != '0) ? STEP_LAST_SCALED : STEP_LAST_PLAIN;

  // steps 0..3: corner/size times model size, steps 4..7: letterbox rescale
  always_comb begin
    mul_a = '0;
    mul_b = cfg.inv_scale;
    if (!step_r[2]) begin
      case (step_r[1:0])
        2'd0:    mul_a = VW'($signed({ent_r.cx[15], ent_r.cx, 1'b0}) - 18'(ent_r.bw));
        2'd1:    mul_a = VW'($signed({ent_r.cy[15], ent_r.cy, 1'b0}) - 18'(ent_r.bh));
        2'd2:    mul_a = VW'(ent_r.bw);
        2'd3:    mul_a = VW'(ent_r.bh);
        default: mul_a = '0;
      endcase
      mul_b = step_r[0] ? 24'(cfg.model_h) : 24'(cfg.model_w);
    end else begin
      mul_a = val_r[step_r[1:0]];
    end
    mul_b_s  = {1'b0, mul_b};
    prod_nxt = mul_a * mul_b_s;
  end

  // round half away from zero
  always_comb begin
    mag = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
    if (step_r[2]) begin
      rnd = (mag + (PW'(1) << 15)) >> 16;
    end else if (step_r[1]) begin
      rnd = (mag + (PW'(1) << 13)) >> 14;
    end else begin
      rnd = (mag + (PW'(1) << 14)) >> 15;
    end
    res = prod_r[PW-1] ? (PW'(0) - rnd) : rnd;
  end

  always_comb begin
    ow = (cfg.image_w != '0) ? cfg.image_w : {1'b0, cfg.model_w};
    oh = (cfg.image_h != '0) ? cfg.image_h : {1'b0, cfg.model_h};
    if (ow > IMG_MAX_W) ow = IMG_MAX_W;
    if (oh > IMG_MAX_W) oh = IMG_MAX_W;
    ow_s = $signed(CW'(ow));
    oh_s = $signed(CW'(oh));

    x_c = CW'(val_r[0]);
    if (x_c > ow_s - ONE_S) x_c = ow_s - ONE_S;
    if (x_c < 0) x_c = '0;
    y_c = CW'(val_r[1]);
    if (y_c > oh_s - ONE_S) y_c = oh_s - ONE_S;
    if (y_c < 0) y_c = '0;

    w_c = CW'(val_r[2]);
    if (w_c > ow_s - CW'(val_r[0])) w_c = ow_s - CW'(val_r[0]);
    if (w_c < ONE_S) w_c = ONE_S;
    h_c = CW'(val_r[3]);
    if (h_c > oh_s - CW'(val_r[1])) h_c = oh_s - CW'(val_r[1]);
    if (h_c < ONE_S) h_c = ONE_S;
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = keep ? S_MUL : S_IDLE;
      S_MUL:   state_nxt = S_RND;
      S_RND:   state_nxt = (step_r == step_last) ? S_CLXY : S_MUL;
      S_CLXY:  state_nxt = S_CLWH;
      S_CLWH:  state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CHECK) begin
        step_r <= '0;
      end else if (state_r == S_RND) begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r  <= q_head;
      conf_r <= SIG_TABLE[sig_idx];
    end
    if (state_r == S_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == S_RND) begin
      val_r[step_r[1:0]] <= $signed(res[VW-1:0]);
    end
    if (state_r == S_CLXY) begin
      val_r[0] <= x_c[VW-1:0];
      val_r[1] <= y_c[VW-1:0];
    end
    if (state_r == S_CLWH) begin
      val_r[2] <= w_c[VW-1:0];
      val_r[3] <= h_c[VW-1:0];
    end
    if (out_load) begin
      rx_r  <= val_r[0][12:0];
      ry_r  <= val_r[1][12:0];
      rw_r  <= val_r[2][13:0];
      rh_r  <= val_r[3][13:0];
      cls_r <= ent_r.best_class;
      cf_r  <= conf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.rect_x         = rx_r;
  assign out_chan.rect_y         = ry_r;
  assign out_chan.rect_width     = rw_r;
  assign out_chan.rect_height    = rh_r;
  assign out_chan.class_id       = cls_r;
  assign out_chan.confidence_out = cf_r;

  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rw_r != '0) && (rh_r != '0))
    else $error("rectangle with zero size");

  a_check_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_CHECK))
    else $error("popped entry not checked");

  a_scale_steps: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RND) && step_r[2]) |-> (cfg.inv_scale != '0))
    else $error("rescale step without scale");

endmodule
